[sv/st_pkg.sv]
// Shared types, token kinds and character classifiers for the source tokenizer.
// Used by st_front, st_queue, st_back and source_tokenizer.
`default_nettype none
package st_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int KEYWORD_MAX_LEN  = 8;
  localparam int NUM_KEYWORDS     = 13;
  localparam logic [7:0] ERROR_LIMIT_RST = 8'd20;

  localparam logic [5:0] KIND_IDENT   = 6'd13;
  localparam logic [5:0] KIND_INTEGER = 6'd14;
  localparam logic [5:0] KIND_PLUS    = 6'd15;
  localparam logic [5:0] KIND_MINUS   = 6'd16;
  localparam logic [5:0] KIND_STAR    = 6'd17;
  localparam logic [5:0] KIND_SLASH   = 6'd18;
  localparam logic [5:0] KIND_ASSIGN  = 6'd19;
  localparam logic [5:0] KIND_LT      = 6'd20;
  localparam logic [5:0] KIND_GT      = 6'd21;
  localparam logic [5:0] KIND_LE      = 6'd22;
  localparam logic [5:0] KIND_GE      = 6'd23;
  localparam logic [5:0] KIND_EQ      = 6'd24;
  localparam logic [5:0] KIND_NE      = 6'd25;
  localparam logic [5:0] KIND_AND     = 6'd26;
  localparam logic [5:0] KIND_OR      = 6'd27;
  localparam logic [5:0] KIND_BANG    = 6'd28;
  localparam logic [5:0] KIND_LPAREN  = 6'd29;
  localparam logic [5:0] KIND_RPAREN  = 6'd30;
  localparam logic [5:0] KIND_LBRACE  = 6'd31;
  localparam logic [5:0] KIND_RBRACE  = 6'd32;
  localparam logic [5:0] KIND_COLON   = 6'd33;
  localparam logic [5:0] KIND_SEMI    = 6'd34;
  localparam logic [5:0] KIND_EOF     = 6'd35;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_SLASH, MODE_COMMENT, MODE_IDENT,
    MODE_NUMBER, MODE_OP, MODE_STOPPED
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic        is_error;
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] offset;
    logic [15:0] length;
    logic [63:0] value;
    logic        end_marker;
  } tok_t;

  // One input word produces up to three tokens; they travel together.
  typedef struct packed {
    logic [1:0]      cnt;
    tok_t [2:0]      tok;
  } bundle_t;

  // Keyword text packed right-aligned, first byte most significant.
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h66756e, 64'h72657475726e, 64'h6c6574, 64'h6966, 64'h656c7365,
    64'h7768696c65, 64'h666f72, 64'h627265616b, 64'h636f6e74696e7565,
    64'h74727565, 64'h66616c7365, 64'h693332, 64'h626f6f6c
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd6, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd4, 4'd5, 4'd3, 4'd4
  };

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic logic [5:0] word_kind(input logic [63:0] buf_v, input logic [15:0] len);
    logic [5:0] k;
    k = KIND_IDENT;
    if (len <= 16'(KEYWORD_MAX_LEN)) begin
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
        if (len == 16'(KW_LEN[i]) && buf_v == KW_TEXT[i]) k = 6'(i);
      end
    end
    return k;
  endfunction

  // {found, kind}
  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] r;
    unique case (b)
      8'h2b:   r = {1'b1, KIND_PLUS};
      8'h2d:   r = {1'b1, KIND_MINUS};
      8'h2a:   r = {1'b1, KIND_STAR};
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h7b:   r = {1'b1, KIND_LBRACE};
      8'h7d:   r = {1'b1, KIND_RBRACE};
      8'h3a:   r = {1'b1, KIND_COLON};
      8'h3b:   r = {1'b1, KIND_SEMI};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_op_start(input logic [7:0] b);
    return b == 8'h3d || b == 8'h3c || b == 8'h3e || b == 8'h21 || b == 8'h26 || b == 8'h7c;
  endfunction

  function automatic logic [6:0] one_char_kind(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      8'h3d:   r = {1'b1, KIND_ASSIGN};
      8'h3c:   r = {1'b1, KIND_LT};
      8'h3e:   r = {1'b1, KIND_GT};
      8'h21:   r = {1'b1, KIND_BANG};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] two_char_kind(input logic [7:0] c, input logic [7:0] b);
    logic [6:0] r;
    unique case (c)
      8'h3d:   r = (b == 8'h3d) ? {1'b1, KIND_EQ}  : 7'd0;
      8'h3c:   r = (b == 8'h3d) ? {1'b1, KIND_LE}  : 7'd0;
      8'h3e:   r = (b == 8'h3d) ? {1'b1, KIND_GE}  : 7'd0;
      8'h21:   r = (b == 8'h3d) ? {1'b1, KIND_NE}  : 7'd0;
      8'h26:   r = (b == 8'h26) ? {1'b1, KIND_AND} : 7'd0;
      8'h7c:   r = (b == 8'h7c) ? {1'b1, KIND_OR}  : 7'd0;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/st_front.sv]
// Front end: lexer state, one input word per cycle while accept is high, builds a bundle of tokens.
// Depends on st_pkg.
`default_nettype none
module st_front #(
  parameter int OFFSET_WIDTH = st_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            operation,
  input  wire logic [7:0]      byte_in,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  output st_pkg::bundle_t      bundle,
  output logic                 push
);

  st_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt, ecnt_r, ecnt_nxt, limit_r, limit_nxt;
  logic [31:0] tline_r, tline_nxt, tcol_r, tcol_nxt, cline_r, cline_nxt, ccol_r, ccol_nxt;
  logic [OFFSET_WIDTH-1:0] toff_r, toff_nxt, coff_r, coff_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [63:0] kw_r, kw_nxt, num_r, num_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= st_pkg::MODE_IDLE;
      pend_r  <= '0;
      ecnt_r  <= '0;
      limit_r <= st_pkg::ERROR_LIMIT_RST;
      tline_r <= 32'd1;
      tcol_r  <= 32'd1;
      cline_r <= 32'd1;
      ccol_r  <= 32'd1;
      toff_r  <= '0;
      coff_r  <= '0;
      tlen_r  <= '0;
      kw_r    <= '0;
      num_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      ecnt_r  <= ecnt_nxt;
      limit_r <= limit_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      cline_r <= cline_nxt;
      ccol_r  <= ccol_nxt;
      toff_r  <= toff_nxt;
      coff_r  <= coff_nxt;
      tlen_r  <= tlen_nxt;
      kw_r    <= kw_nxt;
      num_r   <= num_nxt;
    end
  end

  always_comb begin
    logic       done;
    logic [1:0] n;
    logic [6:0] k;
    logic [7:0] b;
    st_pkg::tok_t t;

    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    ecnt_nxt  = ecnt_r;
    limit_nxt = cfg_we ? cfg_wdata : limit_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    cline_nxt = cline_r;
    ccol_nxt  = ccol_r;
    toff_nxt  = toff_r;
    coff_nxt  = coff_r;
    tlen_nxt  = tlen_r;
    kw_nxt    = kw_r;
    num_nxt   = num_r;
    bundle    = '0;
    n         = 2'd0;
    done      = 1'b0;
    b         = byte_in;
    t         = '0;
    k         = '0;

    if (accept) begin
      // Continue the pending token where the byte allows it.
      if (operation == st_pkg::OP_BYTE) begin
        case (mode_r)
          st_pkg::MODE_STOPPED: done = 1'b1;
          st_pkg::MODE_COMMENT: begin
            done = 1'b1;
            coff_nxt = coff_nxt + 1'b1;
            if (b == 8'h0a) begin
              cline_nxt = cline_nxt + 32'd1;
              ccol_nxt  = 32'd1;
              mode_nxt  = st_pkg::MODE_IDLE;
            end else begin
              ccol_nxt = ccol_nxt + 32'd1;
            end
          end
          st_pkg::MODE_IDENT: begin
            if (st_pkg::is_letter(b) || st_pkg::is_num(b)) begin
              done = 1'b1;
              if (tlen_r < 16'(st_pkg::KEYWORD_MAX_LEN)) kw_nxt = {kw_r[55:0], b};
              if (tlen_r != 16'hffff) tlen_nxt = tlen_r + 16'd1;
              coff_nxt = coff_nxt + 1'b1;
              ccol_nxt = ccol_nxt + 32'd1;
            end
          end
          st_pkg::MODE_NUMBER: begin
            if (st_pkg::is_num(b)) begin
              done = 1'b1;
              num_nxt = (num_r << 3) + (num_r << 1) + 64'(b - 8'h30);
              if (tlen_r != 16'hffff) tlen_nxt = tlen_r + 16'd1;
              coff_nxt = coff_nxt + 1'b1;
              ccol_nxt = ccol_nxt + 32'd1;
            end
          end
          st_pkg::MODE_SLASH: begin
            if (b == 8'h2f) begin
              done = 1'b1;
              coff_nxt = coff_nxt + 1'b1;
              ccol_nxt = ccol_nxt + 32'd1;
              mode_nxt = st_pkg::MODE_COMMENT;
            end
          end
          st_pkg::MODE_OP: begin
            k = st_pkg::two_char_kind(pend_r, b);
            if (k[6]) begin
              done = 1'b1;
              coff_nxt = coff_nxt + 1'b1;
              ccol_nxt = ccol_nxt + 32'd1;
              t = '{kind: k[5:0], is_error: 1'b0, line: tline_r, column: tcol_r,
                    offset: 32'(toff_r), length: 16'd2, value: 64'd0, end_marker: 1'b0};
              bundle.tok[n] = t;
              n = n + 2'd1;
              mode_nxt = st_pkg::MODE_IDLE;
              if (ecnt_nxt >= limit_r) begin
                t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: cline_nxt,
                      column: ccol_nxt, offset: 32'(coff_nxt), length: 16'd0,
                      value: 64'd0, end_marker: 1'b1};
                bundle.tok[n] = t;
                n = n + 2'd1;
                mode_nxt = st_pkg::MODE_STOPPED;
              end
            end
          end
          default: ;
        endcase
      end

      // Close the pending token.
      if (!done && (mode_r == st_pkg::MODE_IDENT || mode_r == st_pkg::MODE_NUMBER ||
                    mode_r == st_pkg::MODE_SLASH || mode_r == st_pkg::MODE_OP)) begin
        t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: tline_r, column: tcol_r,
              offset: 32'(toff_r), length: 16'd0, value: 64'd0, end_marker: 1'b0};
        case (mode_r)
          st_pkg::MODE_IDENT: begin
            t.kind   = st_pkg::word_kind(kw_r, tlen_r);
            t.length = tlen_r;
          end
          st_pkg::MODE_NUMBER: begin
            t.kind   = st_pkg::KIND_INTEGER;
            t.length = tlen_r;
            t.value  = num_r;
          end
          st_pkg::MODE_SLASH: begin
            t.kind   = st_pkg::KIND_SLASH;
            t.length = 16'd1;
          end
          default: begin
            k = st_pkg::one_char_kind(pend_r);
            if (k[6]) begin
              t.kind   = k[5:0];
              t.length = 16'd1;
            end else begin
              t.is_error = 1'b1;
              if (ecnt_nxt != 8'hff) ecnt_nxt = ecnt_nxt + 8'd1;
            end
          end
        endcase
        bundle.tok[n] = t;
        n = n + 2'd1;
        mode_nxt = st_pkg::MODE_IDLE;
        if (ecnt_nxt >= limit_r) begin
          t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: cline_nxt,
                column: ccol_nxt, offset: 32'(coff_nxt), length: 16'd0,
                value: 64'd0, end_marker: 1'b1};
          bundle.tok[n] = t;
          n = n + 2'd1;
          mode_nxt = st_pkg::MODE_STOPPED;
        end
      end

      if (operation == st_pkg::OP_END) begin
        if (mode_nxt != st_pkg::MODE_STOPPED) begin
          t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: cline_nxt,
                column: ccol_nxt, offset: 32'(coff_nxt), length: 16'd0,
                value: 64'd0, end_marker: 1'b1};
          bundle.tok[n] = t;
          n = n + 2'd1;
        end
        mode_nxt  = st_pkg::MODE_IDLE;
        pend_nxt  = '0;
        ecnt_nxt  = '0;
        tline_nxt = 32'd1;
        tcol_nxt  = 32'd1;
        cline_nxt = 32'd1;
        ccol_nxt  = 32'd1;
        toff_nxt  = '0;
        coff_nxt  = '0;
        tlen_nxt  = '0;
        kw_nxt    = '0;
        num_nxt   = '0;
      end else if (!done && mode_nxt != st_pkg::MODE_STOPPED) begin
        // Start a new token from idle.
        if (st_pkg::is_blank(b)) begin
          coff_nxt = coff_nxt + 1'b1;
          if (b == 8'h0a) begin
            cline_nxt = cline_nxt + 32'd1;
            ccol_nxt  = 32'd1;
          end else begin
            ccol_nxt = ccol_nxt + 32'd1;
          end
        end else begin
          tline_nxt = cline_nxt;
          tcol_nxt  = ccol_nxt;
          toff_nxt  = coff_nxt;
          coff_nxt  = coff_nxt + 1'b1;
          ccol_nxt  = ccol_nxt + 32'd1;
          k = st_pkg::single_kind(b);
          if (b == 8'h2f) begin
            mode_nxt = st_pkg::MODE_SLASH;
          end else if (st_pkg::is_op_start(b)) begin
            pend_nxt = b;
            mode_nxt = st_pkg::MODE_OP;
          end else if (st_pkg::is_letter(b)) begin
            kw_nxt   = 64'(b);
            tlen_nxt = 16'd1;
            mode_nxt = st_pkg::MODE_IDENT;
          end else if (st_pkg::is_num(b)) begin
            num_nxt  = 64'(b - 8'h30);
            tlen_nxt = 16'd1;
            mode_nxt = st_pkg::MODE_NUMBER;
          end else begin
            t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: tline_nxt,
                  column: tcol_nxt, offset: 32'(toff_nxt), length: 16'd0,
                  value: 64'd0, end_marker: 1'b0};
            if (k[6]) begin
              t.kind   = k[5:0];
              t.length = 16'd1;
            end else begin
              t.is_error = 1'b1;
              if (ecnt_nxt != 8'hff) ecnt_nxt = ecnt_nxt + 8'd1;
            end
            bundle.tok[n] = t;
            n = n + 2'd1;
            if (ecnt_nxt >= limit_r) begin
              t = '{kind: st_pkg::KIND_EOF, is_error: 1'b0, line: cline_nxt,
                    column: ccol_nxt, offset: 32'(coff_nxt), length: 16'd0,
                    value: 64'd0, end_marker: 1'b1};
              bundle.tok[n] = t;
              n = n + 2'd1;
              mode_nxt = st_pkg::MODE_STOPPED;
            end
          end
        end
      end
    end

    bundle.cnt = n;
    push = accept && (n != 2'd0);
  end

endmodule
`default_nettype wire

[sv/st_queue.sv]
// Short register FIFO of token bundles between front and back end.
// Depends on st_pkg.
`default_nettype none
module st_queue #(
  parameter int QUEUE_DEPTH = st_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  st_pkg::bundle_t      wdata,
  input  wire logic            pop,
  output st_pkg::bundle_t      head,
  output logic                 not_empty,
  output logic                 not_full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  st_pkg::bundle_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != CW'(QUEUE_DEPTH));

endmodule
`default_nettype wire

[sv/st_back.sv]
// Back end: walks the head bundle and hands out one token word per cycle while out_ready is high.
// Depends on st_pkg.
`default_nettype none
module st_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  st_pkg::bundle_t      head,
  input  wire logic            not_empty,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output st_pkg::tok_t         tok,
  output logic                 pop
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

  always_comb begin
    out_valid = not_empty;
    tok       = head.tok[idx_r];
    last      = (idx_r == head.cnt - 2'd1);
    pop       = out_valid && out_ready && last;
    idx_nxt   = idx_r;
    // advance within the bundle, wrap on its last token
    if (out_valid && out_ready) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

endmodule
`default_nettype wire

[sv/source_tokenizer.sv]
// Streaming lexer: source bytes in, tokens out, with position and value.
// Uses st_front, st_queue and st_back; types from st_pkg.
//
// Input channel (in_*): one word per source byte (in_operation = 0) and an
// end-of-source word (in_operation = 1). Output channel (out_*): one word per
// token. Both use valid/ready; a word moves when both are high.
// cfg_we writes the error limit from cfg_wdata; write it only while idle.
// Throughput: one input word per cycle while the FIFO is not full; the front
// end decides all tokens of a byte in the cycle it is taken. Tokens of one
// byte (up to three) leave one per cycle while out_ready is high, through a
// QUEUE_DEPTH-entry bundle FIFO that registers each bundle on acceptance.
// in_ready drops only while that FIFO is full, so a stalled receiver
// back-pressures the source after QUEUE_DEPTH bundles.
// Reset (rst_n low, synchronous) empties the FIFO, sets position to line 1,
// column 1, offset 0, clears the error count and sets the error limit to 20.
`default_nettype none
module source_tokenizer #(
  parameter int OFFSET_WIDTH = st_pkg::OFFSET_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = st_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic [7:0]         in_byte_req,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              out_kind,
  output logic                    out_is_error,
  output logic [31:0]             out_start_line,
  output logic [31:0]             out_start_column,
  output logic [31:0]             out_start_offset,
  output logic [15:0]             out_length,
  output logic signed [63:0]      out_number_value,
  output logic                    out_end_marker
);

  st_pkg::bundle_t bundle, head;
  st_pkg::tok_t    tok;
  logic push, pop, not_empty, not_full;

  assign in_ready = not_full;

  st_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
    .clk, .rst_n,
    .accept    (in_valid && in_ready),
    .operation (in_operation),
    .byte_in   (in_byte_req),
    .cfg_we, .cfg_wdata,
    .bundle, .push
  );

  st_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push,
    .wdata (bundle),
    .pop, .head, .not_empty, .not_full
  );

  st_back u_back (
    .clk, .rst_n, .head, .not_empty, .out_ready, .out_valid, .tok, .pop
  );

  assign out_kind         = tok.kind;
  assign out_is_error     = tok.is_error;
  assign out_start_line   = tok.line;
  assign out_start_column = tok.column;
  assign out_start_offset = tok.offset;
  assign out_length       = tok.length;
  assign out_number_value = tok.value;
  assign out_end_marker   = tok.end_marker;

endmodule
`default_nettype wire

[sv/st_checker.sv]
// Port-level checks for source_tokenizer, attached by bind.
// Depends on st_pkg and the top level's ports.
`default_nettype none
module st_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_kind,
  input wire logic        out_is_error,
  input wire logic [15:0] out_length,
  input wire logic        out_end_marker
);

  // a stalled token word stays valid with the same kind
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("token word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token word after reset");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_marker |->
      out_kind == st_pkg::KIND_EOF && !out_is_error && out_length == 16'd0)
    else $error("malformed end-of-file token");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_kind == st_pkg::KIND_EOF && out_length == 16'd0)
    else $error("malformed error token");

endmodule

bind source_tokenizer st_checker u_st_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_kind, .out_is_error,
  .out_length, .out_end_marker
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for source_tokenizer: directed byte table, then random
// token-shaped text, checked against a built-in lexer predictor. Needs st_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  logic clk, rst_n;
  logic in_valid, in_ready, in_operation;
  logic [7:0] in_byte_req;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic out_valid, out_ready;
  logic [5:0] out_kind;
  logic out_is_error, out_end_marker;
  logic [31:0] out_start_line, out_start_column, out_start_offset;
  logic [15:0] out_length;
  logic signed [63:0] out_number_value;

  source_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_byte_req(in_byte_req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_is_error(out_is_error),
    .out_start_line(out_start_line), .out_start_column(out_start_column),
    .out_start_offset(out_start_offset), .out_length(out_length),
    .out_number_value(out_number_value), .out_end_marker(out_end_marker)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [7:0] lim;
  st_pkg::mode_t mode;
  logic [7:0] pend;
  logic [31:0] t_line, t_col, t_off, c_line, c_col, c_off;
  logic [15:0] t_len;
  logic [63:0] kw_buf, num_acc;
  logic [7:0] err_cnt;
  st_pkg::tok_t token_q[$];
  st_pkg::tok_t row_q[$];
  int fails;
  int send_idle, recv_idle;
  longint cycles;

  // directed table: {op, byte, check_first, kind, is_error}
  typedef struct {
    logic op;
    logic [7:0] b;
    logic chk;
    logic [5:0] kind;
    logic is_err;
  } row_t;
  row_t dir_rows[$];

  function automatic st_pkg::tok_t mk(logic [5:0] k, logic e, logic [31:0] l,
                                      logic [31:0] c, logic [31:0] o, logic [15:0] n,
                                      logic [63:0] v, logic m);
    st_pkg::tok_t t;
    t.kind = k; t.is_error = e; t.line = l; t.column = c; t.offset = o;
    t.length = n; t.value = v; t.end_marker = m;
    return t;
  endfunction

  function automatic logic letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [5:0] classify_word(logic [63:0] w, logic [15:0] n);
    logic [63:0] names[13];
    int lens[13];
    names = '{"fun", "return", "let", "if", "else", "while", "for", "break",
              "continue", "true", "false", "i32", "bool"};
    lens = '{3, 6, 3, 2, 4, 6 - 1, 3, 5, 8, 4, 5, 3, 4};
    if (n > 8) return st_pkg::KIND_IDENT;
    for (int i = 0; i < 13; i++)
      if (n == lens[i] && w == names[i]) return 6'(i);
    return st_pkg::KIND_IDENT;
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] b);
    case (b)
      "+": return st_pkg::KIND_PLUS;
      "-": return st_pkg::KIND_MINUS;
      "*": return st_pkg::KIND_STAR;
      "(": return st_pkg::KIND_LPAREN;
      ")": return st_pkg::KIND_RPAREN;
      "{": return st_pkg::KIND_LBRACE;
      "}": return st_pkg::KIND_RBRACE;
      ":": return st_pkg::KIND_COLON;
      ";": return st_pkg::KIND_SEMI;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] c, logic [7:0] b);
    if (c == "&") return b == "&" ? st_pkg::KIND_AND : 6'd0;
    if (c == "|") return b == "|" ? st_pkg::KIND_OR : 6'd0;
    if (b != "=") return 6'd0;
    case (c)
      "=": return st_pkg::KIND_EQ;
      "<": return st_pkg::KIND_LE;
      ">": return st_pkg::KIND_GE;
      "!": return st_pkg::KIND_NE;
      default: return 6'd0;
    endcase
  endfunction

  task automatic new_source();
    mode = st_pkg::MODE_IDLE; pend = '0; t_line = 1; t_col = 1; t_off = 0; t_len = 0;
    kw_buf = '0; num_acc = '0; c_line = 1; c_col = 1; c_off = 0; err_cnt = '0;
  endtask

  // append a predicted token for the checker and for the directed rows
  task automatic enqueue(st_pkg::tok_t t);
    token_q.insert(token_q.size(), t);
    row_q.insert(row_q.size(), t);
  endtask

  task automatic push_tok(logic [5:0] k, logic [15:0] n, logic [63:0] v);
    enqueue(mk(k, 1'b0, t_line, t_col, t_off, n, v, 1'b0));
  endtask

  task automatic push_err();
    enqueue(mk(st_pkg::KIND_EOF, 1'b1, t_line, t_col, t_off, 16'd0, 64'd0, 1'b0));
    if (err_cnt != 8'hff) err_cnt++;
  endtask

  task automatic halt_check();
    if (err_cnt >= lim) begin
      enqueue(mk(st_pkg::KIND_EOF, 1'b0, c_line, c_col, c_off, 16'd0, 64'd0, 1'b1));
      mode = st_pkg::MODE_STOPPED;
    end
  endtask

  task automatic advance(logic [7:0] b);
    c_off++;
    if (b == 8'h0a) begin
      c_line++;
      c_col = 1;
    end else c_col++;
  endtask

  task automatic close_pending();
    logic [5:0] k;
    case (mode)
      st_pkg::MODE_IDENT: push_tok(classify_word(kw_buf, t_len), t_len, 64'd0);
      st_pkg::MODE_NUMBER: push_tok(st_pkg::KIND_INTEGER, t_len, num_acc);
      st_pkg::MODE_SLASH: push_tok(st_pkg::KIND_SLASH, 16'd1, 64'd0);
      st_pkg::MODE_OP: begin
        case (pend)
          "=": k = st_pkg::KIND_ASSIGN;
          "<": k = st_pkg::KIND_LT;
          ">": k = st_pkg::KIND_GT;
          "!": k = st_pkg::KIND_BANG;
          default: k = 6'd0;
        endcase
        if (k == 6'd0) push_err();
        else push_tok(k, 16'd1, 64'd0);
      end
      default: return;
    endcase
    mode = st_pkg::MODE_IDLE;
    halt_check();
  endtask

  task automatic lex_word(logic op, logic [7:0] b);
    logic [5:0] k;
    if (op == st_pkg::OP_END) begin
      close_pending();
      if (mode != st_pkg::MODE_STOPPED)
        enqueue(mk(st_pkg::KIND_EOF, 1'b0, c_line, c_col, c_off, 16'd0, 64'd0, 1'b1));
      new_source();
      return;
    end
    case (mode)
      st_pkg::MODE_STOPPED: return;
      st_pkg::MODE_COMMENT: begin
        advance(b);
        if (b == 8'h0a) mode = st_pkg::MODE_IDLE;
        return;
      end
      st_pkg::MODE_IDENT: if (letter(b) || digit(b)) begin
        if (t_len < 8) kw_buf = {kw_buf[55:0], b};
        if (t_len != 16'hffff) t_len++;
        advance(b);
        return;
      end
      st_pkg::MODE_NUMBER: if (digit(b)) begin
        num_acc = num_acc * 10 + 64'(b - "0");
        if (t_len != 16'hffff) t_len++;
        advance(b);
        return;
      end
      st_pkg::MODE_SLASH: if (b == "/") begin
        advance(b);
        mode = st_pkg::MODE_COMMENT;
        return;
      end
      st_pkg::MODE_OP: begin
        k = pair_kind(pend, b);
        if (k != 6'd0) begin
          advance(b);
          push_tok(k, 16'd2, 64'd0);
          mode = st_pkg::MODE_IDLE;
          halt_check();
          return;
        end
      end
      default: ;
    endcase
    close_pending();
    if (mode == st_pkg::MODE_STOPPED) return;
    if (b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d) begin
      advance(b);
      return;
    end
    t_line = c_line; t_col = c_col; t_off = c_off;
    advance(b);
    k = punct_kind(b);
    if (k != 6'd0) begin
      push_tok(k, 16'd1, 64'd0);
      halt_check();
    end else if (b == "/") mode = st_pkg::MODE_SLASH;
    else if (b == "=" || b == "<" || b == ">" || b == "!" || b == "&" || b == "|") begin
      pend = b;
      mode = st_pkg::MODE_OP;
    end else if (letter(b)) begin
      kw_buf = 64'(b); t_len = 1; mode = st_pkg::MODE_IDENT;
    end else if (digit(b)) begin
      num_acc = 64'(b - "0"); t_len = 1; mode = st_pkg::MODE_NUMBER;
    end else begin
      push_err();
      halt_check();
    end
  endtask

  // drive one word and wait for it to be taken; valid stays up for the next word
  task automatic send_word(logic op, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_byte_req <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lex_word(op, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(st_pkg::OP_BYTE, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim = v;
  endtask

  // random well-formed-ish fragment
  task automatic send_fragment();
    string frags[20];
    int n;
    frags = '{"fun ", "return ", "let ", "if", "else ", "while ", "for ", "break;",
              "continue ", "true ", "false ", "i32 ", "bool ", "== ", "<=", ">=",
              "!=", "&&", "||", "// note\n"};
    case ($urandom_range(5))
      0: send_text(frags[$urandom_range(19)]);
      1: begin
        n = $urandom_range(1, 12);
        send_word(st_pkg::OP_BYTE, "a" + 8'($urandom_range(25)));
        repeat (n) send_word(st_pkg::OP_BYTE,
                             $urandom_range(1) ? "_" + 8'd0 : "0" + 8'($urandom_range(9)));
      end
      2: repeat ($urandom_range(1, 22))
           send_word(st_pkg::OP_BYTE, "0" + 8'($urandom_range(9)));
      3: send_text(" \t\r\n");
      4: send_word(st_pkg::OP_BYTE, 8'($urandom_range(255)));
      default: send_word(st_pkg::OP_BYTE, "(" + 8'($urandom_range(1)));
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    st_pkg::tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token kind %0d", $realtime, out_kind);
        fails++;
      end else begin
        want = token_q.pop_front();
        if (want.kind != out_kind || want.is_error != out_is_error ||
            want.line != out_start_line || want.column != out_start_column ||
            want.offset != out_start_offset || want.length != out_length ||
            want.value != out_number_value || want.end_marker != out_end_marker) begin
          $display("%0t: expected k%0d e%0d %0d:%0d @%0d len%0d v%0d m%0d", $realtime,
                   want.kind, want.is_error, want.line, want.column, want.offset,
                   want.length, want.value, want.end_marker);
          $display("%0t: actual   k%0d e%0d %0d:%0d @%0d len%0d v%0d m%0d", $realtime,
                   out_kind, out_is_error, out_start_line, out_start_column,
                   out_start_offset, out_length, out_number_value, out_end_marker);
          fails++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    fails = 0; cycles = 0; send_idle = 21; recv_idle = 45;
    rst_n = 1'b0; in_valid = 1'b0; in_operation = 1'b0; in_byte_req = '0;
    cfg_we = 1'b0; cfg_wdata = '0; out_ready = 1'b0;
    lim = st_pkg::ERROR_LIMIT_RST;
    new_source();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; end word right away yields EOF at reset position
    dir_rows = '{
      '{st_pkg::OP_END, 8'h00, 1'b1, st_pkg::KIND_EOF, 1'b0},
      '{st_pkg::OP_BYTE, 8'h00, 1'b1, st_pkg::KIND_EOF, 1'b1},
      '{st_pkg::OP_BYTE, 8'hff, 1'b1, st_pkg::KIND_EOF, 1'b1},
      '{st_pkg::OP_BYTE, "&", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, "x", 1'b1, st_pkg::KIND_EOF, 1'b1},
      '{st_pkg::OP_BYTE, "|", 1'b1, st_pkg::KIND_IDENT, 1'b0},
      '{st_pkg::OP_BYTE, "|", 1'b1, st_pkg::KIND_OR, 1'b0},
      '{st_pkg::OP_BYTE, "=", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, "9", 1'b1, st_pkg::KIND_ASSIGN, 1'b0},
      '{st_pkg::OP_BYTE, "/", 1'b1, st_pkg::KIND_INTEGER, 1'b0},
      '{st_pkg::OP_BYTE, "/", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, "!", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, 8'h0a, 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, "<", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_BYTE, "=", 1'b1, st_pkg::KIND_LE, 1'b0},
      '{st_pkg::OP_BYTE, "/", 1'b0, 6'd0, 1'b0},
      '{st_pkg::OP_END, 8'h00, 1'b1, st_pkg::KIND_SLASH, 1'b0}
    };
    foreach (dir_rows[i]) begin
      row_q.delete();
      send_word(dir_rows[i].op, dir_rows[i].b);
      if (dir_rows[i].chk && (row_q.size() == 0 ||
          row_q[0].kind != dir_rows[i].kind ||
          row_q[0].is_error != dir_rows[i].is_err)) begin
        $display("%0t: row %0d expected kind %0d err %0d", $realtime, i,
                 dir_rows[i].kind, dir_rows[i].is_err);
        fails++;
      end
    end
    send_text("fun continue 18446744073709551616 longidentifier ");
    send_word(st_pkg::OP_END, 8'h00);
    drain();

    // error limit of one: stop after the first error
    write_limit(8'd1);
    send_text("a#b c");
    send_word(st_pkg::OP_END, 8'h00);
    drain();
    write_limit(8'd255);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 45; recv_idle = 21;
        drain();
        write_limit(8'd3);
      end else if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
        drain();
        write_limit(8'd20);
      end
      for (int n = 0; n < 14; n++) begin
        send_fragment();
        if ($urandom_range(7) == 0) send_word(st_pkg::OP_END, 8'($urandom_range(255)));
      end
      send_word(st_pkg::OP_END, 8'h00);
      row_q.delete();
    end

    drain();
    if (fails == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire

[source_tokenizer.f]
sv/st_pkg.sv
sv/st_front.sv
sv/st_queue.sv
sv/st_back.sv
sv/source_tokenizer.sv
sv/st_checker.sv
tb/tb_top.sv
